// File: design/bao_pkg.sv
// shared types and constants for the bump allocator with object-start bitmap
// used by bao_front, bao_back and bump_allocator_object_bitmap_core
`default_nettype none

package bao_pkg;

  // operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_REG   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_OOM   = 2'd1;
  localparam logic [1:0] STS_MISAL = 2'd2;
  localparam logic [1:0] STS_RANGE = 2'd3;

  // register index
  localparam logic REG_CAPACITY = 1'b0;

  localparam int OP_W   = 2;
  localparam int SIZE_W = 17;
  localparam int OFF_W  = 16;
  localparam int CAP_W  = 18;   // rounded capacity may reach 2^17
  localparam int STS_W  = 2;

  localparam int HEAP_BYTES_DEF = 65536;
  localparam int CAP_RESET      = 65536;

  // bitmap rows: 64 words of 8 bytes per row
  localparam int WORD_SHIFT = 3;
  localparam int ROW_BITS   = 64;
  localparam int ROW_SHIFT  = 6;
  localparam int BIT_LO     = WORD_SHIFT;
  localparam int BIT_HI     = WORD_SHIFT + ROW_SHIFT - 1;
  localparam int MAX_WORDS  = 8192;  // reachable with a 16-bit offset

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  offset;
    logic              misaligned;
    logic              out_of_range;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic init;   // reset clearing pass still running
  } bk_stat_t;

endpackage

`default_nettype wire

// File: design/bao_front.sv
// front end: takes transactions, classifies them and queues them for the back end
// depends on bao_pkg
`default_nettype none

module bao_front (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  wire [bao_pkg::OP_W-1:0]    in_operation,
  input  wire [bao_pkg::SIZE_W-1:0]  in_size_bytes,
  input  wire [bao_pkg::OFF_W-1:0]   in_offset,
  input  wire [bao_pkg::CAP_W-1:0]   cap_eff,
  input  wire bao_pkg::bk_stat_t     bk_stat,
  output logic                       q_valid,
  output bao_pkg::cmd_t              q_cmd
);

  bao_pkg::cmd_t q_mem_r [2];
  logic [1:0]    cnt_r, cnt_nxt;
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic          push;
  bao_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.op           = in_operation;
    cmd_in.size         = in_size_bytes;
    cmd_in.offset       = in_offset;
    cmd_in.misaligned   = |in_offset[bao_pkg::WORD_SHIFT-1:0];
    cmd_in.out_of_range = {{(bao_pkg::CAP_W-bao_pkg::OFF_W){1'b0}}, in_offset} >= cap_eff;
  end

  assign busy    = (cnt_r == 2'd2) || bk_stat.init;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt    = cnt_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (bk_stat.pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !bk_stat.pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && bk_stat.pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// File: design/bao_back.sv
// back end: bump pointer, object-start bitmap memory and result registers
// depends on bao_pkg; fed by bao_front through its command queue
`default_nettype none

module bao_back #(
  parameter int HEAP_BYTES = bao_pkg::HEAP_BYTES_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        q_valid,
  input  wire bao_pkg::cmd_t         q_cmd,
  input  wire [bao_pkg::CAP_W-1:0]   cap_eff,
  output bao_pkg::bk_stat_t          bk_stat,
  output logic                       out_strobe,
  output logic [bao_pkg::OFF_W-1:0]  out_alloc_offset,
  output logic                       out_hit,
  output logic [bao_pkg::STS_W-1:0]  out_status
);

  localparam int HEAP_WORDS = (HEAP_BYTES + 7) / 8;
  localparam int MAP_WORDS  = (HEAP_WORDS < bao_pkg::MAX_WORDS) ? HEAP_WORDS
                                                                 : bao_pkg::MAX_WORDS;
  localparam int ROWS   = (MAP_WORDS + bao_pkg::ROW_BITS - 1) / bao_pkg::ROW_BITS;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_MODIFY = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;

  logic [bao_pkg::ROW_BITS-1:0] map_mem [ROWS];
  logic [bao_pkg::ROW_BITS-1:0] rd_data_r;

  logic [2:0]                  state_r, state_nxt;
  logic [bao_pkg::SIZE_W-1:0]  used_r, used_nxt;
  logic [ROW_AW-1:0]           sweep_r, sweep_nxt;
  logic [bao_pkg::OFF_W-1:0]   cur_off_r, cur_off_nxt;
  logic                        strobe_r, strobe_nxt;
  logic [bao_pkg::OFF_W-1:0]   alloc_r, alloc_nxt;
  logic                        hit_r, hit_nxt;
  logic [bao_pkg::STS_W-1:0]   sts_r, sts_nxt;

  logic                        rd_en, wr_en;
  logic [ROW_AW-1:0]           rd_addr, wr_addr;
  logic [bao_pkg::ROW_BITS-1:0] wr_data;
  logic [bao_pkg::CAP_W-1:0]   next_used;
  logic [bao_pkg::ROW_SHIFT-1:0] cur_bit;

  assign next_used = {1'b0, used_r} + {1'b0, q_cmd.size};
  assign cur_bit   = cur_off_r[bao_pkg::BIT_HI:bao_pkg::BIT_LO];

  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    sweep_nxt   = sweep_r;
    cur_off_nxt = cur_off_r;
    strobe_nxt  = 1'b0;
    alloc_nxt   = '0;
    hit_nxt     = 1'b0;
    sts_nxt     = bao_pkg::STS_OK;
    bk_stat.pop  = 1'b0;
    bk_stat.init = (state_r == S_INIT);
    rd_en   = 1'b0;
    rd_addr = ROW_AW'(q_cmd.offset >> (bao_pkg::WORD_SHIFT + bao_pkg::ROW_SHIFT));
    wr_en   = 1'b0;
    wr_addr = sweep_r;
    wr_data = '0;

    unique case (state_r)
      S_INIT, S_CLEAR: begin
        wr_en     = 1'b1;
        sweep_nxt = sweep_r + ROW_AW'(1);
        if (sweep_r == LAST_ROW) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
          // the clear transaction reports once the whole map is zero
          strobe_nxt = (state_r == S_CLEAR);
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          bk_stat.pop = 1'b1;
          cur_off_nxt = q_cmd.offset;
          unique case (q_cmd.op)
            bao_pkg::OP_ALLOC: begin
              strobe_nxt = 1'b1;
              if (next_used >= cap_eff) begin
                sts_nxt = bao_pkg::STS_OOM;
              end else begin
                alloc_nxt = used_r[bao_pkg::OFF_W-1:0];
                used_nxt  = next_used[bao_pkg::SIZE_W-1:0];
              end
            end
            bao_pkg::OP_REG: begin
              if (q_cmd.misaligned) begin
                strobe_nxt = 1'b1;
                sts_nxt    = bao_pkg::STS_MISAL;
              end else if (q_cmd.out_of_range) begin
                strobe_nxt = 1'b1;
                sts_nxt    = bao_pkg::STS_RANGE;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_MODIFY;
              end
            end
            bao_pkg::OP_QUERY: begin
              if (q_cmd.misaligned || ({1'b0, q_cmd.offset} >= used_r)) begin
                strobe_nxt = 1'b1;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_READ;
              end
            end
            bao_pkg::OP_CLEAR: begin
              used_nxt  = '0;
              sweep_nxt = '0;
              state_nxt = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        strobe_nxt = 1'b1;
        hit_nxt    = rd_data_r[cur_bit];
        state_nxt  = S_IDLE;
      end
      S_MODIFY: begin
        wr_en      = 1'b1;
        wr_addr    = ROW_AW'(cur_off_r >> (bao_pkg::WORD_SHIFT + bao_pkg::ROW_SHIFT));
        wr_data    = rd_data_r | (bao_pkg::ROW_BITS'(1) << cur_bit);
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      used_r   <= '0;
      sweep_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      sweep_r  <= sweep_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_off_r <= cur_off_nxt;
    alloc_r   <= alloc_nxt;
    hit_r     <= hit_nxt;
    sts_r     <= sts_nxt;
  end

  // bitmap memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= map_mem[rd_addr];
    end
  end

  assign out_strobe       = strobe_r;
  assign out_alloc_offset = alloc_r;
  assign out_hit          = hit_r;
  assign out_status       = sts_r;

endmodule

`default_nettype wire

// File: design/bump_allocator_object_bitmap_core.sv
// top level: configuration registers, front end and back end of the bump allocator
// depends on bao_pkg, bao_front and bao_back
//
// channel   direction  handshake                  payload
// input     in         start / busy               in_operation, in_size_bytes, in_offset
// result    out        out_strobe (one cycle)     out_alloc_offset, out_hit, out_status
// config    in/out     psel/penable/pwrite/pready paddr, pwdata, prdata
//
// a transaction is registered in the two-entry queue, then the back end takes it when idle:
// allocate and rejected register or query report from the idle state, a bitmap
// register or query after a memory read, then modify or test, clear after the sweep
// of ROWS = heap words / 64 rows (128 at the default heap size), one row zeroed per cycle.
// after reset the bitmap memory is swept with busy high.
// busy rises when the queue is full; the result side never stalls.
`default_nettype none

module bump_allocator_object_bitmap_core #(
  parameter int HEAP_BYTES = bao_pkg::HEAP_BYTES_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  wire [bao_pkg::OP_W-1:0]    in_operation,
  input  wire [bao_pkg::SIZE_W-1:0]  in_size_bytes,
  input  wire [bao_pkg::OFF_W-1:0]   in_offset,
  output logic                       out_strobe,
  output logic [bao_pkg::OFF_W-1:0]  out_alloc_offset,
  output logic                       out_hit,
  output logic [bao_pkg::STS_W-1:0]  out_status,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [2:0]                  paddr,
  input  wire [31:0]                 pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam logic [24:0] HEAP_W = 25'(HEAP_BYTES);
  localparam logic [24:0] CAP_RST_W = 25'(bao_pkg::CAP_RESET);
  localparam logic [bao_pkg::CAP_W-1:0] CAP_EFF_RST =
    (CAP_RST_W > HEAP_W) ? bao_pkg::CAP_W'(HEAP_BYTES) : bao_pkg::CAP_W'(bao_pkg::CAP_RESET);

  logic [bao_pkg::SIZE_W-1:0] cap_r, cap_nxt;
  logic [bao_pkg::CAP_W-1:0]  cap_eff_r, cap_eff_nxt;
  logic [bao_pkg::CAP_W-1:0]  cap_round;
  logic                       cfg_wr;
  logic                       q_valid;
  bao_pkg::cmd_t              q_cmd;
  bao_pkg::bk_stat_t          bk_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == bao_pkg::REG_CAPACITY);

  // round up to a multiple of 8, then limit to the heap size
  assign cap_round = ({1'b0, pwdata[bao_pkg::SIZE_W-1:0]} + bao_pkg::CAP_W'(7))
                     & ~bao_pkg::CAP_W'(7);

  always_comb begin
    cap_nxt     = cap_r;
    cap_eff_nxt = cap_eff_r;
    if (cfg_wr) begin
      cap_nxt = pwdata[bao_pkg::SIZE_W-1:0];
      if ({7'd0, cap_round} > HEAP_W) begin
        cap_eff_nxt = bao_pkg::CAP_W'(HEAP_BYTES);
      end else begin
        cap_eff_nxt = cap_round;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= bao_pkg::SIZE_W'(bao_pkg::CAP_RESET);
      cap_eff_r <= CAP_EFF_RST;
    end else begin
      cap_r     <= cap_nxt;
      cap_eff_r <= cap_eff_nxt;
    end
  end

  assign prdata = (paddr[2] == bao_pkg::REG_CAPACITY)
                  ? {{(32-bao_pkg::SIZE_W){1'b0}}, cap_r} : 32'd0;

  bao_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_size_bytes(in_size_bytes),
    .in_offset    (in_offset),
    .cap_eff      (cap_eff_r),
    .bk_stat      (bk_stat),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd)
  );

  bao_back #(
    .HEAP_BYTES(HEAP_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .cap_eff         (cap_eff_r),
    .bk_stat         (bk_stat),
    .out_strobe      (out_strobe),
    .out_alloc_offset(out_alloc_offset),
    .out_hit         (out_hit),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire

// File: bench/tb_bump_allocator_object_bitmap_core.sv
// testbench for bump_allocator_object_bitmap_core: directed and random allocate, register,
// query and clear commands under several heap capacities, checked by a scoreboard class
// depends on bao_pkg and the design files of bump_allocator_object_bitmap_core
`timescale 1ns / 100ps

module tb_bump_allocator_object_bitmap_core;
  import bao_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int MAP_WORDS  = HEAP_BYTES_DEF / 8;
  localparam logic [2:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

  typedef struct {
    logic [OFF_W-1:0] alloc_offset;
    logic             hit;
    logic [STS_W-1:0] status;
  } heap_result_t;

  // keeps its own heap state and the results still owed by the block
  class heap_scoreboard;
    int unsigned  capacity;
    int unsigned  used_bytes;
    bit           object_map [MAP_WORDS];
    heap_result_t pending_results [$];
    int unsigned  errors;
    int unsigned  n_ops [4];
    int unsigned  n_hits, n_oom, n_rejected;

    function new();
      capacity   = CAP_RESET;
      used_bytes = 0;
      errors     = 0;
      n_hits     = 0;
      n_oom      = 0;
      n_rejected = 0;
      foreach (object_map[i]) object_map[i] = 1'b0;
      foreach (n_ops[i]) n_ops[i] = 0;
    endfunction

    function void set_capacity(logic [SIZE_W-1:0] value);
      capacity = value;
    endfunction

    // rounded up to 8 bytes and limited to the heap size
    function int unsigned usable_capacity();
      int unsigned c;
      c = (capacity + 7) & ~32'd7;
      if (c > HEAP_BYTES_DEF) c = HEAP_BYTES_DEF;
      return c;
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
                               logic [OFF_W-1:0] offset);
      heap_result_t res;
      int unsigned  cap;
      int unsigned  next_used;
      cap = usable_capacity();
      res.alloc_offset = '0;
      res.hit          = 1'b0;
      res.status       = STS_OK;
      n_ops[op]++;
      case (op)
        OP_ALLOC: begin
          next_used = used_bytes + size;
          if (next_used >= cap) begin
            res.status = STS_OOM;
            n_oom++;
          end else begin
            res.alloc_offset = used_bytes[OFF_W-1:0];
            used_bytes = next_used & 32'h1FFFF;
          end
        end
        OP_REG: begin
          if (offset[2:0] != 3'd0) begin
            res.status = STS_MISAL;
            n_rejected++;
          end else if (offset >= cap) begin
            res.status = STS_RANGE;
            n_rejected++;
          end else begin
            object_map[offset >> 3] = 1'b1;
          end
        end
        OP_QUERY: begin
          if (offset[2:0] == 3'd0 && offset < used_bytes && object_map[offset >> 3]) begin
            res.hit = 1'b1;
            n_hits++;
          end
        end
        default: begin
          used_bytes = 0;
          foreach (object_map[i]) object_map[i] = 1'b0;
        end
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [OFF_W-1:0] alloc_offset, logic hit,
                               logic [STS_W-1:0] status);
      heap_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: alloc_offset %0d hit %0b status %0d",
               alloc_offset, hit, status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (alloc_offset !== want.alloc_offset) begin
        $error("alloc_offset mismatch: expected %0d, actual %0d",
               want.alloc_offset, alloc_offset);
        errors++;
      end
      if (hit !== want.hit) begin
        $error("hit mismatch: expected %0b, actual %0b", want.hit, hit);
        errors++;
      end
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_operation = OP_ALLOC;
  logic [SIZE_W-1:0] in_size_bytes = '0;
  logic [OFF_W-1:0]  in_offset = '0;
  logic              out_strobe;
  logic [OFF_W-1:0]  out_alloc_offset;
  logic              out_hit;
  logic [STS_W-1:0]  out_status;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  heap_scoreboard heap_sb;
  int unsigned    idle_cycles = 0;
  int unsigned    n_cfg_writes = 0;

  bump_allocator_object_bitmap_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_size_bytes    (in_size_bytes),
    .in_offset        (in_offset),
    .out_strobe       (out_strobe),
    .out_alloc_offset (out_alloc_offset),
    .out_hit          (out_hit),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe) heap_sb.check_result(out_alloc_offset, out_hit, out_status);
  end

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_bump_allocator_object_bitmap_core failed");
      $finish;
    end
  end

  task automatic push_command(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
                              logic [OFF_W-1:0] offset);
    start         <= 1'b1;
    in_operation  <= op;
    in_size_bytes <= size;
    in_offset     <= offset;
    do @(posedge clk); while (busy);
    heap_sb.note_command(op, size, offset);
  endtask

  task automatic pause(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic step_command(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
                              logic [OFF_W-1:0] offset);
    push_command(op, size, offset);
    if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 4));
  endtask

  // wait until every transaction has reported, then write the capacity register
  task automatic write_capacity(logic [SIZE_W-1:0] value);
    start <= 1'b0;
    while (heap_sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    heap_sb.set_capacity(value);
    n_cfg_writes++;
  endtask

  // mostly aligned offsets near the used mark so that marks get hit
  function automatic logic [OFF_W-1:0] pick_offset(int unsigned upper);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (upper < 8) upper = 8;
    if (upper > HEAP_BYTES_DEF) upper = HEAP_BYTES_DEF;
    if (r < 80) return OFF_W'($urandom_range(0, upper - 1) & ~32'd7);
    if (r < 90) return OFF_W'($urandom_range(0, 65535) & ~32'd7);
    return OFF_W'($urandom_range(0, 65535));
  endfunction

  task automatic pick_command(output logic [OP_W-1:0] op, output logic [SIZE_W-1:0] size,
                              output logic [OFF_W-1:0] offset);
    int unsigned r;
    int unsigned cap;
    int unsigned s;
    r   = $urandom_range(0, 99);
    cap = heap_sb.usable_capacity();
    s   = $urandom_range(0, 99);
    size   = SIZE_W'($urandom_range(0, 131071));
    offset = OFF_W'($urandom_range(0, 65535));
    if (r < 40) begin
      op = OP_ALLOC;
      if (s < 60) size = SIZE_W'($urandom_range(0, cap / 12 + 1));
      else if (s < 85) size = SIZE_W'($urandom_range(0, 16) * 8);
    end else if (r < 65) begin
      op = OP_REG;
      offset = pick_offset((heap_sb.used_bytes + 64 < cap) ? heap_sb.used_bytes + 64 : cap);
    end else if (r < 96) begin
      op = OP_QUERY;
      offset = pick_offset(heap_sb.used_bytes + 16);
    end else begin
      op = OP_CLEAR;
    end
  endtask

  // bursts of random length, with gaps between them unless the phase runs flat out
  task automatic run_random(int unsigned n_items);
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  offset;
    int unsigned       burst_left;
    bit                flat_out;
    flat_out   = ($urandom_range(0, 3) == 0);
    burst_left = $urandom_range(1, 16);
    for (int unsigned i = 0; i < n_items; i++) begin
      pick_command(op, size, offset);
      push_command(op, size, offset);
      burst_left--;
      if (burst_left == 0) begin
        if (!flat_out) pause($urandom_range(1, 9));
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  initial begin
    heap_sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // full heap: bump pointer edges, marks above and below the used mark
    step_command(OP_QUERY, 0, 0);
    step_command(OP_ALLOC, 0, 0);
    step_command(OP_ALLOC, 64, 0);
    step_command(OP_REG, 0, 0);
    step_command(OP_REG, 0, 16'hFFFF);
    step_command(OP_REG, 0, 65528);
    step_command(OP_QUERY, 0, 0);
    step_command(OP_QUERY, 0, 8);
    step_command(OP_QUERY, 0, 65528);
    step_command(OP_ALLOC, 65472, 0);
    step_command(OP_ALLOC, 65471, 0);
    step_command(OP_ALLOC, 0, 0);
    step_command(OP_ALLOC, 17'h1FFFF, 0);
    step_command(OP_QUERY, 0, 65528);
    step_command(OP_QUERY, 0, 16'hFFFF);
    step_command(OP_CLEAR, 0, 0);
    step_command(OP_QUERY, 0, 0);

    // smallest heap, then zero capacity with marks left behind
    write_capacity(8);
    step_command(OP_ALLOC, 7, 0);
    step_command(OP_ALLOC, 0, 0);
    step_command(OP_ALLOC, 1, 0);
    step_command(OP_REG, 0, 0);
    step_command(OP_REG, 0, 8);
    step_command(OP_QUERY, 0, 0);
    write_capacity(0);
    step_command(OP_ALLOC, 0, 0);
    step_command(OP_REG, 0, 0);
    step_command(OP_QUERY, 0, 0);

    // random phases; no clear between them, so shrinking leaves used above capacity
    write_capacity(17'h1FFFF);
    run_random(70);
    write_capacity(4096);
    run_random(60);
    write_capacity(65536);
    run_random(70);
    write_capacity(200);
    run_random(60);
    write_capacity(1);
    run_random(40);
    write_capacity(SIZE_W'($urandom_range(8, 65536)));
    run_random(70);
    write_capacity(0);
    run_random(30);
    write_capacity(65536);
    run_random(100);

    start <= 1'b0;
    while (heap_sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d allocate (%0d out of memory), %0d register (%0d rejected),",
             heap_sb.n_ops[OP_ALLOC], heap_sb.n_oom, heap_sb.n_ops[OP_REG],
             heap_sb.n_rejected);
    $display("%0d query (%0d hits) and %0d clear commands over %0d capacity settings",
             heap_sb.n_ops[OP_QUERY], heap_sb.n_hits, heap_sb.n_ops[OP_CLEAR],
             n_cfg_writes + 1);
    if (heap_sb.errors == 0) begin
      $display("tb_bump_allocator_object_bitmap_core passed");
    end else begin
      $display("tb_bump_allocator_object_bitmap_core failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/bao_pkg.sv
design/bao_front.sv
design/bao_back.sv
design/bump_allocator_object_bitmap_core.sv
bench/tb_bump_allocator_object_bitmap_core.sv
